[sv/asrb_pkg.sv]
// ----------------------------------------------------------------------------
// asrb_pkg: shared types and constants for the playback ring
// Ring geometry, command, status and register codes, and the structs passed
// between the controller and the top level.
// ----------------------------------------------------------------------------
package asrb_pkg;

  localparam int RING_FRAMES = 8192;
  localparam int IDX_W       = $clog2(RING_FRAMES);
  localparam int CNT_W       = $clog2(RING_FRAMES + 1);

  localparam int SAMPLE_W    = 16;
  localparam int FRAME_W     = 2 * SAMPLE_W;
  localparam int DRV_W       = 32;
  localparam int TOTAL_W     = 48;
  localparam int THR_W       = 14;
  localparam int QF_W        = 14;
  localparam int CMP_W       = 32;

  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;

  // Commands
  localparam logic [CMD_W-1:0] CMD_OPEN       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_END        = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POLL       = 3'd5;
  localparam logic [CMD_W-1:0] CMD_START_DONE = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_OPEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_STEREO       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CARD_STEREO_ONLY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_THRESHOLD  = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET = 14'd4096;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                read_valid;
    logic                rd_stereo;
    logic                start_request;
    logic                stop_card;
    logic                open_flag;
    logic                dma_running;
    logic [QF_W-1:0]     queued_frames;
    logic [TOTAL_W-1:0]  played_src_bytes;
    logic                last_echo;
  } res_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [IDX_W-1:0]   addr;
    logic [FRAME_W-1:0] wdata;
  } ram_req_t;

endpackage

[sv/audio_stream_ring_with_start_threshold_core.sv]
// ----------------------------------------------------------------------------
// audio_stream_ring_with_start_threshold_core: playback ring with start
// threshold
// Queues PCM frames between a writer and the card refill, raises a one-shot
// DMA start request, tracks played bytes and closes a drained stream.
//
//   Channel  Direction  Handshake             Beat contents
//   in_*     in         in_valid / in_stall   command, samples, driver state
//   out_*    out        out_valid / out_stall one result per command
//   cfg_*    in         cfg_valid / cfg_ready register index and data
//
// One command is taken per cycle while in_stall is low; its result appears in
// the output register on the next cycle. The frame store is a single-port RAM
// with a registered read, so popped data arrives with the registered result.
// in_stall rises only while a result waits in the output register and
// out_stall is high; a stalled result and its read data hold.
// Reset (rst_n low, synchronous) clears pointers, flags and counters; the
// frame store is not cleared since entries are read only after a write.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module audio_stream_ring_with_start_threshold_core import asrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  input  logic [DRV_W-1:0]      in_driver_played,
  input  logic                  in_card_was_playing,
  input  logic                  in_card_now_playing,
  input  logic                  in_burst_last,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_read_valid,
  output logic signed [SAMPLE_W-1:0] out_left,
  output logic signed [SAMPLE_W-1:0] out_right,
  output logic                  out_start_request,
  output logic                  out_stop_card,
  output logic                  out_open_flag,
  output logic                  out_dma_running,
  output logic [QF_W-1:0]       out_queued_frames,
  output logic [TOTAL_W-1:0]    out_played_src_bytes,
  output logic                  out_last_echo,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic               accept;
  logic               out_valid_r;
  res_t               res_nxt;
  res_t               res_r;
  ram_req_t           ram_req;
  logic [FRAME_W-1:0] ram_rdata;

  // Advance whenever the output register is empty or drains this cycle.
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  asrb_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .accept           (accept),
    .cmd              (in_cmd),
    .left_sample      (in_left_sample),
    .right_sample     (in_right_sample),
    .driver_played    (in_driver_played),
    .card_was_playing (in_card_was_playing),
    .card_now_playing (in_card_now_playing),
    .burst_last       (in_burst_last),
    .res_nxt          (res_nxt),
    .ram_req          (ram_req)
  );

  // Frame store: left sample in the low half, right in the high half.
  asrb_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (RING_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  // Result register; the popped frame joins it from the RAM read register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = res_r.status;
  assign out_read_valid       = res_r.read_valid;
  assign out_left             = res_r.read_valid ? ram_rdata[SAMPLE_W-1:0] : '0;
  assign out_right            = (res_r.read_valid && res_r.rd_stereo)
                                ? ram_rdata[FRAME_W-1:SAMPLE_W] : '0;
  assign out_start_request    = res_r.start_request;
  assign out_stop_card        = res_r.stop_card;
  assign out_open_flag        = res_r.open_flag;
  assign out_dma_running      = res_r.dma_running;
  assign out_queued_frames    = res_r.queued_frames;
  assign out_played_src_bytes = res_r.played_src_bytes;
  assign out_last_echo        = res_r.last_echo;

endmodule

[sv/asrb_ram.sv]
// ----------------------------------------------------------------------------
// asrb_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module asrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/asrb_ctrl.sv]
// ----------------------------------------------------------------------------
// asrb_ctrl: stream state and command decode
// Holds ring pointers, fill count, stream flags, played byte total and the
// configuration registers; computes one result per accepted beat.
// ----------------------------------------------------------------------------
module asrb_ctrl import asrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [SAMPLE_W-1:0]   left_sample,
  input  logic [SAMPLE_W-1:0]   right_sample,
  input  logic [DRV_W-1:0]      driver_played,
  input  logic                  card_was_playing,
  input  logic                  card_now_playing,
  input  logic                  burst_last,
  output res_t                  res_nxt,
  output ram_req_t              ram_req
);

  logic [IDX_W-1:0]   ridx_r, ridx_nxt;
  logic [IDX_W-1:0]   widx_r, widx_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               open_r, open_nxt;
  logic               ended_r, ended_nxt;
  logic               dma_r, dma_nxt;
  logic               pend_r, pend_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [DRV_W-1:0]   prev_r, prev_nxt;

  logic               src_stereo_r;
  logic               card_so_r;
  logic [THR_W-1:0]   thr_r;

  logic               card_stereo;
  logic               upmix;
  logic [SAMPLE_W-1:0] right_w;
  logic [CMP_W-1:0]   fill_cmp;
  logic [CMP_W-1:0]   thr_cmp;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_FRAMES - 1)) ? '0 : i + 1'b1;
  endfunction

  assign card_stereo = src_stereo_r | card_so_r;
  assign upmix       = ~src_stereo_r & card_so_r;
  assign right_w     = upmix ? left_sample : (card_stereo ? right_sample : '0);

  always_comb begin
    ridx_nxt  = ridx_r;
    widx_nxt  = widx_r;
    fill_nxt  = fill_r;
    open_nxt  = open_r;
    ended_nxt = ended_r;
    dma_nxt   = dma_r;
    pend_nxt  = pend_r;
    total_nxt = total_r;
    prev_nxt  = prev_r;

    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.addr  = ridx_r;
    ram_req.wdata = {right_w, left_sample};

    res_nxt               = '0;
    res_nxt.status        = ST_OK;
    res_nxt.rd_stereo     = card_stereo;
    res_nxt.last_echo     = burst_last;

    fill_cmp = '0;
    thr_cmp  = '0;

    unique case (cmd)
      CMD_OPEN: begin
        res_nxt.stop_card = open_r;
        ridx_nxt  = '0;
        widx_nxt  = '0;
        fill_nxt  = '0;
        ended_nxt = 1'b0;
        dma_nxt   = 1'b0;
        pend_nxt  = 1'b0;
        total_nxt = '0;
        prev_nxt  = '0;
        open_nxt  = 1'b1;
      end
      CMD_WRITE: begin
        if (!open_r) begin
          res_nxt.status = ST_NO_OPEN;
        end else if (fill_r >= CNT_W'(RING_FRAMES)) begin
          res_nxt.status = ST_FULL;
        end else begin
          ram_req.we   = accept;
          ram_req.addr = widx_r;
          widx_nxt     = next_idx(widx_r);
          fill_nxt     = fill_r + 1'b1;
        end
      end
      CMD_READ: begin
        if (!open_r) begin
          res_nxt.status = ST_NO_OPEN;
        end else if (fill_r == '0) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          ram_req.re         = accept;
          res_nxt.read_valid = 1'b1;
          ridx_nxt           = next_idx(ridx_r);
          fill_nxt           = fill_r - 1'b1;
        end
      end
      CMD_END: begin
        if (open_r) begin
          ended_nxt = 1'b1;
        end else begin
          res_nxt.status = ST_NO_OPEN;
        end
      end
      CMD_STOP: begin
        res_nxt.stop_card = open_r;
        ridx_nxt  = '0;
        widx_nxt  = '0;
        fill_nxt  = '0;
        open_nxt  = 1'b0;
        ended_nxt = 1'b0;
        dma_nxt   = 1'b0;
        pend_nxt  = 1'b0;
        total_nxt = '0;
        prev_nxt  = '0;
      end
      CMD_POLL: begin
        if (!open_r) begin
          res_nxt.status = ST_NO_OPEN;
        end else begin
          if (dma_r) begin
            if (driver_played >= prev_r) begin
              total_nxt = total_r + TOTAL_W'(driver_played - prev_r);
            end
            prev_nxt = card_now_playing ? driver_played : '0;
            if (card_was_playing && !card_now_playing) begin
              dma_nxt = 1'b0;
            end
          end
          if (dma_r && card_was_playing && !card_now_playing && ended_r) begin
            // drained close: the ended stream's DMA was running and the card stopped
            res_nxt.stop_card = 1'b1;
            ridx_nxt  = '0;
            widx_nxt  = '0;
            fill_nxt  = '0;
            open_nxt  = 1'b0;
            ended_nxt = 1'b0;
            dma_nxt   = 1'b0;
            pend_nxt  = 1'b0;
            total_nxt = '0;
            prev_nxt  = '0;
          end else begin
            fill_cmp = CMP_W'(fill_r);
            thr_cmp  = CMP_W'(thr_r);
            if (!dma_nxt && !pend_r &&
                ((fill_cmp >= thr_cmp) || (ended_r && fill_r != '0))) begin
              pend_nxt              = 1'b1;
              res_nxt.start_request = 1'b1;
            end
          end
        end
      end
      CMD_START_DONE: begin
        pend_nxt = 1'b0;
        if (open_r) begin
          dma_nxt  = 1'b1;
          prev_nxt = '0;
        end else begin
          res_nxt.status = ST_NO_OPEN;
        end
      end
      default: begin
      end
    endcase

    res_nxt.open_flag        = open_nxt;
    res_nxt.dma_running      = dma_nxt;
    res_nxt.queued_frames    = QF_W'(fill_nxt);
    res_nxt.played_src_bytes = upmix ? (total_nxt >> 1) : total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ridx_r  <= '0;
      widx_r  <= '0;
      fill_r  <= '0;
      open_r  <= 1'b0;
      ended_r <= 1'b0;
      dma_r   <= 1'b0;
      pend_r  <= 1'b0;
      total_r <= '0;
      prev_r  <= '0;
    end else if (accept) begin
      ridx_r  <= ridx_nxt;
      widx_r  <= widx_nxt;
      fill_r  <= fill_nxt;
      open_r  <= open_nxt;
      ended_r <= ended_nxt;
      dma_r   <= dma_nxt;
      pend_r  <= pend_nxt;
      total_r <= total_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_stereo_r <= 1'b1;
      card_so_r    <= 1'b0;
      thr_r        <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_STEREO:       src_stereo_r <= cfg_data[0];
        CFG_CARD_STEREO_ONLY: card_so_r    <= cfg_data[0];
        CFG_START_THRESHOLD:  thr_r        <= THR_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

endmodule

[verif/tb_audio_stream_ring_with_start_threshold_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_stream_ring_with_start_threshold_core: playback ring testbench
// Drives command beats into the ring and predicts every result beat with an
// in-bench model of the stream state and frame store. Covers the stream
// commands, the start threshold at its extremes, drained close, a mono
// source upmixed for a stereo-only card, and back-pressure on both channels
// under several settings of the source and card formats.
// ----------------------------------------------------------------------------
module tb_audio_stream_ring_with_start_threshold_core;
  import asrb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  // One predicted result beat.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                read_valid;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                start_request;
    logic                stop_card;
    logic                open_flag;
    logic                dma_running;
    logic [QF_W-1:0]     queued_frames;
    logic [TOTAL_W-1:0]  played_src_bytes;
    logic                last_echo;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd = CMD_OPEN;
  logic [SAMPLE_W-1:0]   in_left_sample = '0;
  logic [SAMPLE_W-1:0]   in_right_sample = '0;
  logic [DRV_W-1:0]      in_driver_played = '0;
  logic                  in_card_was_playing = 1'b0;
  logic                  in_card_now_playing = 1'b0;
  logic                  in_burst_last = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_read_valid;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                  out_start_request;
  logic                  out_stop_card;
  logic                  out_open_flag;
  logic                  out_dma_running;
  logic [QF_W-1:0]       out_queued_frames;
  logic [TOTAL_W-1:0]    out_played_src_bytes;
  logic                  out_last_echo;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SRC_STEREO;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  audio_stream_ring_with_start_threshold_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_left_sample      (in_left_sample),
    .in_right_sample     (in_right_sample),
    .in_driver_played    (in_driver_played),
    .in_card_was_playing (in_card_was_playing),
    .in_card_now_playing (in_card_now_playing),
    .in_burst_last       (in_burst_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_read_valid      (out_read_valid),
    .out_left            (out_left),
    .out_right           (out_right),
    .out_start_request   (out_start_request),
    .out_stop_card       (out_stop_card),
    .out_open_flag       (out_open_flag),
    .out_dma_running     (out_dma_running),
    .out_queued_frames   (out_queued_frames),
    .out_played_src_bytes(out_played_src_bytes),
    .out_last_echo       (out_last_echo),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Ring model: register copies and stream state
  // --------------------------------------------------------------------------
  logic                m_src_stereo = 1'b1;
  logic                m_card_stereo_only = 1'b0;
  logic [THR_W-1:0]    m_threshold = THR_RESET;

  logic [FRAME_W-1:0]  ring_mem [RING_FRAMES];
  logic [IDX_W-1:0]    rd_ptr = '0;
  logic [IDX_W-1:0]    wr_ptr = '0;
  logic [QF_W-1:0]     fill = '0;
  logic                open_q = 1'b0;
  logic                ended_q = 1'b0;
  logic                dma_q = 1'b0;
  logic                start_pend_q = 1'b0;
  logic [TOTAL_W-1:0]  played_total = '0;
  logic [DRV_W-1:0]    drv_prev = '0;

  ring_result_t pending_results [$];
  int mismatch_count = 0;

  // Idling knobs, in percent of cycles; rx_hold_left forces a long stall.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;

  function automatic void clear_stream_model();
    rd_ptr = '0;
    wr_ptr = '0;
    fill = '0;
    open_q = 1'b0;
    ended_q = 1'b0;
    dma_q = 1'b0;
    start_pend_q = 1'b0;
    played_total = '0;
    drv_prev = '0;
  endfunction

  // Advance the model by one command beat and return the result it yields.
  function automatic ring_result_t predict_ring(
    input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] l_smp, r_smp,
    input logic [DRV_W-1:0] drv, input logic was_play, now_play, last_flag);
    ring_result_t r;
    logic card_st;
    logic upmix;
    logic open_before;
    logic drained;
    logic [SAMPLE_W-1:0] r_sel;
    logic [FRAME_W-1:0] word;
    r = '0;
    drained = 1'b0;
    card_st = m_src_stereo | m_card_stereo_only;
    upmix = !m_src_stereo && m_card_stereo_only;
    case (cmd)
      CMD_OPEN: begin
        open_before = open_q;
        clear_stream_model();
        open_q = 1'b1;
        r.stop_card = open_before;
      end
      CMD_WRITE: begin
        if (!open_q) r.status = ST_NO_OPEN;
        else if (fill >= QF_W'(RING_FRAMES)) r.status = ST_FULL;
        else begin
          // mono into a stereo-only card: copy left into right
          r_sel = upmix ? l_smp : (card_st ? r_smp : '0);
          ring_mem[wr_ptr] = {r_sel, l_smp};
          wr_ptr = wr_ptr + 1'b1;
          fill = fill + 1'b1;
        end
      end
      CMD_READ: begin
        if (!open_q) r.status = ST_NO_OPEN;
        else if (fill == '0) r.status = ST_EMPTY;
        else begin
          word = ring_mem[rd_ptr];
          r.left = word[SAMPLE_W-1:0];
          r.right = card_st ? word[FRAME_W-1:SAMPLE_W] : '0;
          r.read_valid = 1'b1;
          rd_ptr = rd_ptr + 1'b1;
          fill = fill - 1'b1;
        end
      end
      CMD_END: begin
        if (open_q) ended_q = 1'b1;
        else r.status = ST_NO_OPEN;
      end
      CMD_STOP: begin
        open_before = open_q;
        clear_stream_model();
        r.stop_card = open_before;
      end
      CMD_POLL: begin
        if (!open_q) r.status = ST_NO_OPEN;
        else begin
          if (dma_q) begin
            // a counter that went back counts as a driver reset
            if (drv >= drv_prev) played_total = played_total + TOTAL_W'(drv - drv_prev);
            drv_prev = now_play ? drv : '0;
            if (was_play && !now_play) begin
              dma_q = 1'b0;
              if (ended_q) begin
                clear_stream_model();
                r.stop_card = 1'b1;
                drained = 1'b1;
              end
            end
          end
          if (!drained && !dma_q && !start_pend_q &&
              (fill >= m_threshold || (ended_q && fill != '0))) begin
            start_pend_q = 1'b1;
            r.start_request = 1'b1;
          end
        end
      end
      CMD_START_DONE: begin
        start_pend_q = 1'b0;
        if (open_q) begin
          dma_q = 1'b1;
          drv_prev = '0;
        end else begin
          r.status = ST_NO_OPEN;
        end
      end
      default: ;
    endcase
    r.open_flag = open_q;
    r.dma_running = dma_q;
    r.queued_frames = fill;
    r.played_src_bytes = upmix ? (played_total >> 1) : played_total;
    r.last_echo = last_flag;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Send one command beat; hold the payload until accepted, then predict it.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] l_smp,
                          input logic [SAMPLE_W-1:0] r_smp, input logic [DRV_W-1:0] drv,
                          input logic was_play, now_play, last_flag);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_left_sample <= l_smp;
    in_right_sample <= r_smp;
    in_driver_played <= drv;
    in_card_was_playing <= was_play;
    in_card_now_playing <= now_play;
    in_burst_last <= last_flag;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_ring(cmd, l_smp, r_smp, drv, was_play, now_play,
                                           last_flag));
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 16'h8000;
    if (roll == 1) return 16'h7FFF;
    return SAMPLE_W'($urandom);
  endfunction

  task automatic send_rand_frame();
    send_cmd(CMD_WRITE, pick_sample(), pick_sample(), $urandom, 1'($urandom_range(1)),
             1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic send_simple(input logic [CMD_W-1:0] cmd);
    send_cmd(cmd, pick_sample(), pick_sample(), $urandom, 1'($urandom_range(1)),
             1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Drop valid and pause until every predicted beat has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all three registers back to back; only call while the ring is idle.
  task automatic program_regs(input logic src, input logic card, input logic [THR_W-1:0] thr);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx[0] = CFG_SRC_STEREO;
    idx[1] = CFG_CARD_STEREO_ONLY;
    idx[2] = CFG_START_THRESHOLD;
    val[0] = CFG_DATA_W'(src);
    val[1] = CFG_DATA_W'(card);
    val[2] = thr;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    m_src_stereo = src;
    m_card_stereo_only = card;
    m_threshold = thr;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a forced hold-off when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [TOTAL_W-1:0] exp_v,
                                      input logic [TOTAL_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Compare each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    ring_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", TOTAL_W'(exp_r.status), TOTAL_W'(out_status));
        check_field("read_valid", TOTAL_W'(exp_r.read_valid), TOTAL_W'(out_read_valid));
        check_field("out_left", TOTAL_W'(exp_r.left), TOTAL_W'($unsigned(out_left)));
        check_field("out_right", TOTAL_W'(exp_r.right), TOTAL_W'($unsigned(out_right)));
        check_field("start_request", TOTAL_W'(exp_r.start_request),
                    TOTAL_W'(out_start_request));
        check_field("stop_card", TOTAL_W'(exp_r.stop_card), TOTAL_W'(out_stop_card));
        check_field("open_flag", TOTAL_W'(exp_r.open_flag), TOTAL_W'(out_open_flag));
        check_field("dma_running", TOTAL_W'(exp_r.dma_running), TOTAL_W'(out_dma_running));
        check_field("queued_frames", TOTAL_W'(exp_r.queued_frames),
                    TOTAL_W'(out_queued_frames));
        check_field("played_src_bytes", exp_r.played_src_bytes, out_played_src_bytes);
        check_field("last_echo", TOTAL_W'(exp_r.last_echo), TOTAL_W'(out_last_echo));
      end
    end
  end

  // Watchdog: end the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Walk every command and corner once on a stereo source.
  task automatic test_directed();
    program_regs(1'b1, 1'b0, 14'd2);
    // nothing open yet: stream commands report no stream, stop and the
    // unused code are quiet
    send_cmd(CMD_WRITE, 16'h1234, 16'h5678, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CMD_READ, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_END, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CMD_POLL, '0, '0, 32'd77, 1'b1, 1'b1, 1'b0);
    send_cmd(CMD_START_DONE, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_STOP, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF, '1, 1'b1, 1'b1, 1'b1);
    // open, then reopen over a live stream to pulse stop_card
    send_cmd(CMD_OPEN, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_OPEN, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_READ, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    // sample extremes in a three-frame burst
    send_cmd(CMD_WRITE, 16'h8000, 16'h7FFF, '0, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_WRITE, 16'h7FFF, 16'h8000, '0, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_WRITE, 16'hFFFF, 16'h0000, '0, 1'b0, 1'b0, 1'b1);
    // threshold reached: one start request, no repeat
    send_cmd(CMD_POLL, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_POLL, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_START_DONE, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    // count up, then go back (driver reset), then jump to the top
    send_cmd(CMD_POLL, '0, '0, 32'd1000, 1'b1, 1'b1, 1'b0);
    send_cmd(CMD_POLL, '0, '0, 32'd500, 1'b1, 1'b1, 1'b0);
    send_cmd(CMD_POLL, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    repeat (3) send_cmd(CMD_READ, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CMD_UNUSED, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    // an ended stream still takes writes, then drains closed when the card stops
    send_cmd(CMD_END, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_WRITE, 16'h0001, 16'hFFFE, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CMD_POLL, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    settle();
  endtask

  // Threshold of zero fires on an empty ring; 16383, above the depth, only via end.
  task automatic test_thresholds();
    program_regs(1'b1, 1'b1, 14'd0);
    send_simple(CMD_OPEN);
    send_cmd(CMD_POLL, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_simple(CMD_START_DONE);
    send_simple(CMD_STOP);
    settle();
    program_regs(1'b0, 1'b0, 14'h3FFF);
    send_simple(CMD_OPEN);
    repeat (3) send_rand_frame();
    send_cmd(CMD_POLL, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_simple(CMD_END);
    send_cmd(CMD_POLL, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_simple(CMD_READ);
    send_simple(CMD_STOP);
    settle();
  endtask

  // Mostly well-formed playback sessions with random content, some noise.
  task automatic run_random(input int beats);
    int counted;
    int next_cfg_at;
    int roll;
    logic [CMD_W-1:0] cmd;
    logic [DRV_W-1:0] drv;
    logic [DRV_W-1:0] drv_run;
    logic [THR_W-1:0] thr;
    logic was_play;
    logic now_play;
    counted = 0;
    next_cfg_at = 0;
    drv_run = '0;
    while (counted < beats) begin
      if (counted >= next_cfg_at) begin
        settle();
        roll = $urandom_range(9);
        thr = (roll == 0) ? 14'd1 : (roll == 1) ? 14'd8192 : THR_W'($urandom_range(48, 2));
        program_regs(1'($urandom_range(1)), 1'($urandom_range(1)), thr);
        next_cfg_at += 100;
      end
      roll = $urandom_range(99);
      if (!open_q) cmd = (roll < 80) ? CMD_OPEN : CMD_W'($urandom_range(7));
      else if (roll < 3) cmd = CMD_W'($urandom_range(7));
      else if (start_pend_q && roll < 30) cmd = CMD_START_DONE;
      else if (roll < 33) cmd = CMD_END;
      else if (roll < 63) cmd = CMD_WRITE;
      else if (roll < 83) cmd = CMD_READ;
      else cmd = CMD_POLL;
      if (open_q || cmd == CMD_OPEN) counted++;
      // driver counter: mostly rising, now and then jumps or goes back
      roll = $urandom_range(99);
      if (roll < 5) drv = $urandom;
      else if (roll < 10) drv = drv_run - DRV_W'($urandom_range(4096, 1));
      else begin
        drv_run = drv_run + DRV_W'($urandom_range(8192));
        drv = drv_run;
      end
      was_play = dma_q ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
      now_play = ended_q ? ($urandom_range(2) != 0) : ($urandom_range(9) != 0);
      if (cmd == CMD_START_DONE) drv_run = DRV_W'($urandom_range(64));
      send_cmd(cmd, pick_sample(), pick_sample(), drv, was_play, now_play,
               1'($urandom_range(1)));
    end
    settle();
  endtask

  // Hold the receiver off while writes keep coming, so the input stalls.
  task automatic test_backpressure();
    program_regs(1'b1, 1'b0, 14'd8);
    send_simple(CMD_OPEN);
    rx_hold_left = HOLD_CYCLES;
    repeat (40) send_rand_frame();
    settle();
    repeat (20) send_simple(CMD_READ);
    send_simple(CMD_STOP);
    settle();
  endtask

  // Upmix mono for a stereo-only card, count played bytes, drain to empty.
  task automatic test_upmix();
    program_regs(1'b0, 1'b1, 14'd32);
    send_simple(CMD_OPEN);
    repeat (40) send_rand_frame();
    send_cmd(CMD_POLL, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_simple(CMD_START_DONE);
    send_cmd(CMD_POLL, '0, '0, 32'd12345, 1'b1, 1'b1, 1'b0);
    send_cmd(CMD_POLL, '0, '0, 32'd12346, 1'b1, 1'b1, 1'b0);
    repeat (41) send_simple(CMD_READ);
    send_simple(CMD_STOP);
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // sender idles a little, receiver stalls a lot
    tx_idle_pct = 26;
    rx_stall_pct = 82;
    test_directed();
    test_thresholds();
    run_random(220);
    // swap the roles
    tx_idle_pct = 82;
    rx_stall_pct = 26;
    run_random(220);
    // full rate on both sides
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_random(220);
    test_backpressure();
    test_upmix();
    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
sv/asrb_pkg.sv
sv/asrb_ram.sv
sv/asrb_ctrl.sv
sv/audio_stream_ring_with_start_threshold_core.sv
verif/tb_audio_stream_ring_with_start_threshold_core.sv
